// File: rtl/core/pmcp_pkg.sv
// ----------------------------------------------------------------------------
// pmcp_pkg
// Shared types, widths and radius table for the mask corner point block.
// ----------------------------------------------------------------------------
package pmcp_pkg;

    localparam int SLOPE_W    = 32;
    localparam int COORD_W    = 12;
    localparam int RAD_W      = 6;
    localparam int DX_FRAC    = 16;
    localparam int DQ_W       = 22;
    localparam int ROOT_W     = 32;
    localparam int SQ_W       = 64;
    localparam int CORD_OUT_W = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [RAD_W-1:0] R_TOP_MANY = 6'd10;
    localparam logic [RAD_W-1:0] R_BOT_MANY = 6'd30;
    localparam logic [RAD_W-1:0] R_TOP_TWO  = 6'd15;
    localparam logic [RAD_W-1:0] R_BOT_TWO  = 6'd35;
    localparam logic [RAD_W-1:0] R_TOP_ONE  = 6'd20;
    localparam logic [RAD_W-1:0] R_BOT_ONE  = 6'd40;
    localparam logic [RAD_W-1:0] R_TOP_NONE = 6'd25;
    localparam logic [RAD_W-1:0] R_BOT_NONE = 6'd45;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [SLOPE_W-1:0]        mag;
        logic                      active;
        logic [RAD_W-1:0]          r_top;
        logic [RAD_W-1:0]          r_bot;
        logic [COORD_W-1:0]        tx;
        logic [COORD_W-1:0]        ty;
        logic [COORD_W-1:0]        bx;
        logic [COORD_W-1:0]        by;
    } item_t;

    typedef struct packed {
        logic [RAD_W-1:0] top;
        logic [RAD_W-1:0] bot;
    } radii_t;

    typedef struct packed {
        logic [CORD_OUT_W-1:0] x;
        logic [CORD_OUT_W-1:0] y;
    } corner_t;

    function automatic radii_t pick_radii(input logic [7:0] buoys);
        radii_t r;
        if (buoys > 8'd2) begin
            r.top = R_TOP_MANY;
            r.bot = R_BOT_MANY;
        end else if (buoys == 8'd2) begin
            r.top = R_TOP_TWO;
            r.bot = R_BOT_TWO;
        end else if (buoys == 8'd1) begin
            r.top = R_TOP_ONE;
            r.bot = R_BOT_ONE;
        end else begin
            r.top = R_TOP_NONE;
            r.bot = R_BOT_NONE;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/perpendicular_mask_corner_points.sv
// ----------------------------------------------------------------------------
// perpendicular_mask_corner_points
// Corner points of a lane mask, offset perpendicular to the lane line.
// ----------------------------------------------------------------------------
// Takes one word per clock while the queue has room and returns one result per
// word, in order. Each word passes through the 32-stage pipelined square root, the
// 22-stage offset dividers and the (SLOPE_FRAC_BITS + 7)-stage y dividers. A
// four-word queue sits behind the input so the front keeps taking words while the
// output is stalled, until the queue is full; the whole arithmetic pipeline stalls
// together when a result waits to be taken.
module perpendicular_mask_corner_points #(
    parameter int COORD_BITS      = 12,
    parameter int SLOPE_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pmcp_pkg::SLOPE_W-1:0]  s_line_slope,
    input  logic                                 s_regression_failed,
    input  logic [7:0]                           s_buoy_count,
    input  logic [pmcp_pkg::COORD_W-1:0]         s_top_x,
    input  logic [pmcp_pkg::COORD_W-1:0]         s_top_y,
    input  logic [pmcp_pkg::COORD_W-1:0]         s_bottom_x,
    input  logic [pmcp_pkg::COORD_W-1:0]         s_bottom_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [15:0]                   m_corner_one_x,
    output logic signed [15:0]                   m_corner_one_y,
    output logic signed [15:0]                   m_corner_two_x,
    output logic signed [15:0]                   m_corner_two_y,
    output logic signed [15:0]                   m_corner_three_x,
    output logic signed [15:0]                   m_corner_three_y,
    output logic signed [15:0]                   m_corner_four_x,
    output logic signed [15:0]                   m_corner_four_y,
    output logic                                 m_corner_one_updated,
    output logic                                 m_corner_two_updated,
    output logic                                 m_corner_three_updated,
    output logic                                 m_corner_four_updated
);

    pmcp_pkg::item_t         front_item;
    pmcp_pkg::item_t         queue_item;
    logic                    queue_valid;
    logic                    queue_pop;
    pmcp_pkg::corner_t [3:0] corner;
    logic [3:0]              updated;

    pmcp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .line_slope        (s_line_slope),
        .regression_failed (s_regression_failed),
        .buoy_count        (s_buoy_count),
        .top_x             (s_top_x),
        .top_y             (s_top_y),
        .bottom_x          (s_bottom_x),
        .bottom_y          (s_bottom_y),
        .item              (front_item)
    );

    pmcp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_item  (front_item),
        .wr_ready (s_ready),
        .rd_valid (queue_valid),
        .rd_item  (queue_item),
        .rd_pop   (queue_pop)
    );

    pmcp_back #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_valid),
        .in_item     (queue_item),
        .in_pop      (queue_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_corner  (corner),
        .out_updated (updated)
    );

    assign m_corner_one_x         = corner[0].x;
    assign m_corner_one_y         = corner[0].y;
    assign m_corner_two_x         = corner[1].x;
    assign m_corner_two_y         = corner[1].y;
    assign m_corner_three_x       = corner[2].x;
    assign m_corner_three_y       = corner[2].y;
    assign m_corner_four_x        = corner[3].x;
    assign m_corner_four_y        = corner[3].y;
    assign m_corner_one_updated   = updated[0];
    assign m_corner_two_updated   = updated[1];
    assign m_corner_three_updated = updated[2];
    assign m_corner_four_updated  = updated[3];

    a_top_update_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_corner_one_updated |-> !m_corner_one_x[15])
        else $error("corner one updated with negative x");

    a_bottom_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_corner_three_updated == m_corner_four_updated))
        else $error("bottom corners updated apart");

    a_root_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_corner_one_updated && m_corner_two_updated
            |-> (m_corner_two_x >= m_corner_one_x))
        else $error("plus root left of minus root");

    a_no_update_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> (updated == 4'b0000) || $past(m_valid))
        else $error("update flags set with no result pending");

endmodule

// File: rtl/core/pmcp_front.sv
// ----------------------------------------------------------------------------
// pmcp_front
// Classifies an incoming word: radii, slope magnitude, hold flag, masked
// coordinates.
// ----------------------------------------------------------------------------
module pmcp_front #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [pmcp_pkg::SLOPE_W-1:0] line_slope,
    input  logic                                regression_failed,
    input  logic [7:0]                          buoy_count,
    input  logic [pmcp_pkg::COORD_W-1:0]        top_x,
    input  logic [pmcp_pkg::COORD_W-1:0]        top_y,
    input  logic [pmcp_pkg::COORD_W-1:0]        bottom_x,
    input  logic [pmcp_pkg::COORD_W-1:0]        bottom_y,
    output pmcp_pkg::item_t                     item
);

    localparam logic [pmcp_pkg::COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= pmcp_pkg::COORD_W) ? {pmcp_pkg::COORD_W{1'b1}}
                                           : pmcp_pkg::COORD_W'((1 << COORD_BITS) - 1);

    pmcp_pkg::radii_t radii;

    assign radii = pmcp_pkg::pick_radii(buoy_count);

    always_comb begin
        item.slope  = line_slope;
        item.mag    = line_slope[pmcp_pkg::SLOPE_W-1] ? pmcp_pkg::SLOPE_W'(-line_slope)
                                                      : pmcp_pkg::SLOPE_W'(line_slope);
        // a flat lane has a vertical perpendicular: hold everything
        item.active = !regression_failed && (line_slope != '0);
        item.r_top  = radii.top;
        item.r_bot  = radii.bot;
        item.tx     = top_x & COORD_MASK;
        item.ty     = top_y & COORD_MASK;
        item.bx     = bottom_x & COORD_MASK;
        item.by     = bottom_y & COORD_MASK;
    end

endmodule

// File: rtl/core/pmcp_queue.sv
// ----------------------------------------------------------------------------
// pmcp_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module pmcp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    input  pmcp_pkg::item_t wr_item,
    output logic            wr_ready,
    output logic            rd_valid,
    output pmcp_pkg::item_t rd_item,
    input  logic            rd_pop
);

    localparam int DEPTH = pmcp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    pmcp_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: rtl/core/pmcp_isqrt.sv
// ----------------------------------------------------------------------------
// pmcp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pmcp_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [pmcp_pkg::SQ_W-1:0]    radicand,
    output logic [pmcp_pkg::ROOT_W-1:0]  root
);

    localparam int SQ_W   = pmcp_pkg::SQ_W;
    localparam int ROOT_W = pmcp_pkg::ROOT_W;

    logic [SQ_W-1:0]   rem_reg [ROOT_W];
    logic [ROOT_W-1:0] res_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [SQ_W+1:0]   trial;

        if (k == 0) begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        // (res + 2^BIT)^2 - res^2
        assign trial = ((SQ_W+2)'(res_in) << (BIT + 1)) + ((SQ_W+2)'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (en) begin
                if ((SQ_W+2)'(rem_in) >= trial) begin
                    rem_reg[k] <= rem_in - trial[SQ_W-1:0];
                    res_reg[k] <= res_in | (ROOT_W'(1) << BIT);
                end else begin
                    rem_reg[k] <= rem_in;
                    res_reg[k] <= res_in;
                end
            end
        end
    end

    assign root = res_reg[ROOT_W-1];

endmodule

// File: rtl/core/pmcp_udiv.sv
// ----------------------------------------------------------------------------
// pmcp_udiv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// The quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module pmcp_udiv #(
    parameter int DIVIDEND_W = 54,
    parameter int DIVISOR_W  = 32,
    parameter int QUOT_W     = 22
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int WORK_W = (DIVIDEND_W > DIVISOR_W + QUOT_W) ? DIVIDEND_W
                                                               : DIVISOR_W + QUOT_W;

    logic [WORK_W-1:0]    rem_reg  [QUOT_W];
    logic [DIVISOR_W-1:0] dvsr_reg [QUOT_W];
    logic [QUOT_W-1:0]    quot_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;
        logic [WORK_W-1:0]    rem_in;
        logic [DIVISOR_W-1:0] dvsr_in;
        logic [QUOT_W-1:0]    quot_in;
        logic [WORK_W-1:0]    trial;

        if (k == 0) begin : g_first
            assign rem_in  = WORK_W'(dividend);
            assign dvsr_in = divisor;
            assign quot_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign dvsr_in = dvsr_reg[k-1];
            assign quot_in = quot_reg[k-1];
        end

        assign trial = WORK_W'(dvsr_in) << BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                dvsr_reg[k] <= dvsr_in;
                if (rem_in >= trial) begin
                    rem_reg[k]  <= rem_in - trial;
                    quot_reg[k] <= quot_in | (QUOT_W'(1) << BIT);
                end else begin
                    rem_reg[k]  <= rem_in;
                    quot_reg[k] <= quot_in;
                end
            end
        end
    end

    assign quotient = quot_reg[QUOT_W-1];

endmodule

// File: rtl/core/pmcp_back.sv
// ----------------------------------------------------------------------------
// pmcp_back
// Arithmetic pipeline: perpendicular offset, corner x and y, hold registers
// and the output stage.
// ----------------------------------------------------------------------------
module pmcp_back #(
    parameter int SLOPE_FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  pmcp_pkg::item_t             in_item,
    output logic                        in_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pmcp_pkg::corner_t [3:0]     out_corner,
    output logic [3:0]                  out_updated
);

    localparam int SQ_W     = pmcp_pkg::SQ_W;
    localparam int ROOT_W   = pmcp_pkg::ROOT_W;
    localparam int DQ_W     = pmcp_pkg::DQ_W;
    localparam int COORD_W  = pmcp_pkg::COORD_W;
    localparam int SLOPE_W  = pmcp_pkg::SLOPE_W;
    localparam int DX_FRAC  = pmcp_pkg::DX_FRAC;
    localparam int OUT_W    = pmcp_pkg::CORD_OUT_W;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DQN_W    = pmcp_pkg::RAD_W + SLOPE_W + DX_FRAC;
    localparam int NUM_W    = COORD_W + SLOPE_W + 2;
    localparam int MAG_W    = NUM_W - 1;
    localparam int QY_W     = SLOPE_FRAC_BITS + 7;
    localparam int XT_W     = COORD_W + 2;
    localparam int D_W      = 8;
    localparam int FL_W     = DQ_W - DX_FRAC + 1;

    typedef struct packed {
        logic                  active;
        logic [3:0]            neg;
        logic [3:0][XT_W-1:0]  xt;
    } tail_t;

    logic adv;

    // stage 1 and 2: slope squared, then plus one
    logic                   valid_s1_reg, valid_s2_reg;
    pmcp_pkg::item_t        item_s1_reg, item_s2_reg;
    logic [SQ_W-1:0]        asq_next, asq_s1_reg;
    logic [SQ_W-1:0]        q_next, q_s2_reg;

    // square root
    logic [SQRT_LAT-1:0]    valid_sq_reg;
    pmcp_pkg::item_t        item_sq_reg [SQRT_LAT];
    logic [ROOT_W-1:0]      root;

    // stage 3: offset dividends
    logic                   valid_s3_reg;
    pmcp_pkg::item_t        item_s3_reg;
    logic [ROOT_W-1:0]      root_s3_reg;
    logic [DQN_W-1:0]       num_top_s3_reg, num_bot_s3_reg;

    // offset dividers
    logic [DQ_W-1:0]        valid_dq_reg;
    pmcp_pkg::item_t        item_dq_reg [DQ_W];
    logic [DQ_W-1:0]        dq_top, dq_bot;

    // stage 4: corner x and slope products
    logic                      valid_s4_reg;
    pmcp_pkg::item_t           item_s4_reg;
    logic signed [D_W-1:0]     d_next [4];
    logic signed [D_W-1:0]     d_s4_reg [4];
    logic [XT_W-1:0]           xt_next [4];
    logic [XT_W-1:0]           xt_s4_reg [4];
    logic signed [NUM_W-1:0]   prod_t_s4_reg, prod_b_s4_reg;

    // stage 5: numerator magnitude and sign
    logic                      valid_s5_reg;
    tail_t                     tail_next, tail_s5_reg;
    logic [SLOPE_W-1:0]        mag_div_s5_reg;
    logic signed [NUM_W-1:0]   num [4];
    logic [MAG_W-1:0]          mag_next [4];
    logic [MAG_W-1:0]          mag_s5_reg [4];

    // y dividers
    logic [QY_W-1:0]           valid_y_reg;
    tail_t                     tail_y_reg [QY_W];
    logic [QY_W-1:0]           qy [4];

    // output stage
    tail_t                     tail_out;
    logic                      last_valid;
    logic [3:0]                upd;
    logic [OUT_W-1:0]          x_sat [4];
    logic [OUT_W-1:0]          y_sat [4];
    logic                      out_valid_reg;
    logic [3:0]                updated_reg;
    pmcp_pkg::corner_t [3:0]   held_reg;

    function automatic logic signed [D_W-1:0] corner_offset(
        input logic [COORD_W-1:0] x0,
        input logic [DQ_W-1:0]    dq,
        input logic               plus
    );
        logic [FL_W-1:0]            fl;
        logic [FL_W-1:0]            cl;
        logic [DQ_W:0]              up;
        logic [COORD_W+DX_FRAC-1:0] x0q;
        fl  = FL_W'(dq >> DX_FRAC);
        up  = (DQ_W+1)'(dq) + (DQ_W+1)'((1 << DX_FRAC) - 1);
        cl  = FL_W'(up >> DX_FRAC);
        x0q = {x0, {DX_FRAC{1'b0}}};
        if (plus) begin
            return D_W'(fl);
        end else if (x0q >= (COORD_W+DX_FRAC)'(dq)) begin
            return -D_W'(cl);
        end else begin
            return -D_W'(fl);
        end
    endfunction

    assign adv    = !out_valid_reg || out_ready;
    assign in_pop = adv && in_valid;

    assign asq_next = SQ_W'(in_item.mag) * SQ_W'(in_item.mag);
    assign q_next   = asq_s1_reg + (SQ_W'(1) << (2 * SLOPE_FRAC_BITS));

    pmcp_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (q_s2_reg),
        .root     (root)
    );

    pmcp_udiv #(
        .DIVIDEND_W (DQN_W),
        .DIVISOR_W  (ROOT_W),
        .QUOT_W     (DQ_W)
    ) u_div_top (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_top_s3_reg),
        .divisor  (root_s3_reg),
        .quotient (dq_top)
    );

    pmcp_udiv #(
        .DIVIDEND_W (DQN_W),
        .DIVISOR_W  (ROOT_W),
        .QUOT_W     (DQ_W)
    ) u_div_bot (
        .aclk     (aclk),
        .en       (adv),
        .dividend (num_bot_s3_reg),
        .divisor  (root_s3_reg),
        .quotient (dq_bot)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d_next[i] = corner_offset((i < 2) ? item_dq_reg[DQ_W-1].tx : item_dq_reg[DQ_W-1].bx,
                                      (i < 2) ? dq_top : dq_bot,
                                      (i == 1) || (i == 2));
            xt_next[i] = XT_W'({1'b0, ((i < 2) ? item_dq_reg[DQ_W-1].tx
                                               : item_dq_reg[DQ_W-1].bx)})
                         + XT_W'(d_next[i]);
        end
    end

    always_comb begin
        tail_next.active = item_s4_reg.active;
        for (int i = 0; i < 4; i++) begin
            num[i] = ((i < 2) ? prod_t_s4_reg : prod_b_s4_reg)
                     - (NUM_W'(d_s4_reg[i]) <<< SLOPE_FRAC_BITS);
            tail_next.neg[i] = num[i][NUM_W-1] ^ item_s4_reg.slope[SLOPE_W-1];
            tail_next.xt[i]  = xt_s4_reg[i];
            mag_next[i]      = num[i][NUM_W-1] ? MAG_W'(-num[i]) : MAG_W'(num[i]);
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_ydiv
        pmcp_udiv #(
            .DIVIDEND_W (MAG_W),
            .DIVISOR_W  (SLOPE_W),
            .QUOT_W     (QY_W)
        ) u_div_y (
            .aclk     (aclk),
            .en       (adv),
            .dividend (mag_s5_reg[i]),
            .divisor  (mag_div_s5_reg),
            .quotient (qy[i])
        );
    end

    assign tail_out   = tail_y_reg[QY_W-1];
    assign last_valid = valid_y_reg[QY_W-1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // top corners left of the image are dropped
            upd[i]   = last_valid && tail_out.active && ((i >= 2) || !tail_out.xt[i][XT_W-1]);
            x_sat[i] = OUT_W'($signed(tail_out.xt[i]));
            if (!tail_out.neg[i]) begin
                x_sat[i] = x_sat[i];
                y_sat[i] = (qy[i] > QY_W'(32767)) ? OUT_W'(32767) : OUT_W'(qy[i]);
            end else begin
                y_sat[i] = (qy[i] > QY_W'(32768)) ? OUT_W'(32768)
                                                  : OUT_W'(-(OUT_W+1)'(qy[i]));
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_s1_reg  <= 1'b0;
            valid_s2_reg  <= 1'b0;
            valid_sq_reg  <= '0;
            valid_s3_reg  <= 1'b0;
            valid_dq_reg  <= '0;
            valid_s4_reg  <= 1'b0;
            valid_s5_reg  <= 1'b0;
            valid_y_reg   <= '0;
            out_valid_reg <= 1'b0;
            updated_reg   <= '0;
            held_reg      <= '0;
        end else if (adv) begin
            valid_s1_reg  <= in_valid;
            valid_s2_reg  <= valid_s1_reg;
            valid_sq_reg  <= {valid_sq_reg[SQRT_LAT-2:0], valid_s2_reg};
            valid_s3_reg  <= valid_sq_reg[SQRT_LAT-1];
            valid_dq_reg  <= {valid_dq_reg[DQ_W-2:0], valid_s3_reg};
            valid_s4_reg  <= valid_dq_reg[DQ_W-1];
            valid_s5_reg  <= valid_s4_reg;
            valid_y_reg   <= {valid_y_reg[QY_W-2:0], valid_s5_reg};
            out_valid_reg <= last_valid;
            updated_reg   <= upd;
            for (int i = 0; i < 4; i++) begin
                if (upd[i]) begin
                    held_reg[i].x <= x_sat[i];
                    held_reg[i].y <= y_sat[i];
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            item_s1_reg    <= in_item;
            asq_s1_reg     <= asq_next;
            item_s2_reg    <= item_s1_reg;
            q_s2_reg       <= q_next;
            item_sq_reg[0] <= item_s2_reg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                item_sq_reg[k] <= item_sq_reg[k-1];
            end
            item_s3_reg    <= item_sq_reg[SQRT_LAT-1];
            root_s3_reg    <= root;
            num_top_s3_reg <= (DQN_W'(item_sq_reg[SQRT_LAT-1].r_top)
                               * DQN_W'(item_sq_reg[SQRT_LAT-1].mag)) << DX_FRAC;
            num_bot_s3_reg <= (DQN_W'(item_sq_reg[SQRT_LAT-1].r_bot)
                               * DQN_W'(item_sq_reg[SQRT_LAT-1].mag)) << DX_FRAC;
            item_dq_reg[0] <= item_s3_reg;
            for (int k = 1; k < DQ_W; k++) begin
                item_dq_reg[k] <= item_dq_reg[k-1];
            end
            item_s4_reg    <= item_dq_reg[DQ_W-1];
            prod_t_s4_reg  <= $signed({1'b0, item_dq_reg[DQ_W-1].ty}) * item_dq_reg[DQ_W-1].slope;
            prod_b_s4_reg  <= $signed({1'b0, item_dq_reg[DQ_W-1].by}) * item_dq_reg[DQ_W-1].slope;
            for (int i = 0; i < 4; i++) begin
                d_s4_reg[i]   <= d_next[i];
                xt_s4_reg[i]  <= xt_next[i];
                mag_s5_reg[i] <= mag_next[i];
            end
            tail_s5_reg    <= tail_next;
            mag_div_s5_reg <= item_s4_reg.mag;
            tail_y_reg[0]  <= tail_s5_reg;
            for (int k = 1; k < QY_W; k++) begin
                tail_y_reg[k] <= tail_y_reg[k-1];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_corner  = held_reg;
    assign out_updated = updated_reg;

endmodule
